// ===== rtl/sorted_list_merge_top_assert.svh =====
// Assertion macros used by the checker file of the sorted list merge block.
`ifndef SORTED_LIST_MERGE_TOP_ASSERT_SVH
`define SORTED_LIST_MERGE_TOP_ASSERT_SVH

// Checked at every rising edge once reset has been released.
`define SLM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at the rising edge that follows each edge at which reset is held.
`define SLM_ASSERT_IN_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) else $error(msg);

`endif

// ===== rtl/slm_pkg.sv =====
// Package: constants, types and codes of the sorted list merge block.
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_WIDTH = 32;
  localparam int VALUE_W    = 32;
  localparam int OP_W       = 2;
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int REM_W      = CNT_W + 1;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [REM_W-1:0]      rem_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_ONE = 2'd0,
    OP_LOAD_TWO = 2'd1,
    OP_MERGE    = 2'd2
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  // Write and read request to one list store.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    addr_t raddr;
  } store_req_t;

endpackage

`default_nettype wire

// ===== rtl/slm_list_store.sv =====
// One list store: a synchronous memory with one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module slm_list_store
  import slm_pkg::*;
(
  input  wire        clk_i,
  input  store_req_t req_i,
  output data_t      rdata_o
);

  data_t mem_q [LIST_DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/slm_merge_ctrl.sv =====
// Merge controller: counts, read pointers, compare and the result register.
`timescale 1ns / 1ps
`default_nettype none

module slm_merge_ctrl
  import slm_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [OP_W-1:0]     in_op_i,
  input  wire  [VALUE_W-1:0]  in_value_i,
  output store_req_t          req_one_o,
  output store_req_t          req_two_o,
  input  data_t               rd_one_i,
  input  data_t               rd_two_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [VALUE_W-1:0]  out_value_o,
  output logic                out_last_o
);

  state_e state_q, state_d;
  cnt_t   cnt_one_q, cnt_one_d, cnt_two_q, cnt_two_d;
  cnt_t   num_one_q, num_one_d, num_two_q, num_two_d;
  cnt_t   idx_one_q, idx_one_d, idx_two_q, idx_two_d;
  rem_t   rem_q, rem_d;
  logic   out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;

  logic   accept, slot_free, more_one, more_two, take_one;
  data_t  pick;
  rem_t   total;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign more_one   = idx_one_q < num_one_q;
  assign more_two   = idx_two_q < num_two_q;
  assign take_one   = more_one && (!more_two || ($signed(rd_one_i) <= $signed(rd_two_i)));
  assign pick       = take_one ? rd_one_i : rd_two_i;
  assign total      = REM_W'(cnt_one_q) + REM_W'(cnt_two_q);

  always_comb begin
    state_d     = state_q;
    cnt_one_d   = cnt_one_q;
    cnt_two_d   = cnt_two_q;
    num_one_d   = num_one_q;
    num_two_d   = num_two_q;
    idx_one_d   = idx_one_q;
    idx_two_d   = idx_two_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    req_one_o   = '0;
    req_two_o   = '0;
    req_one_o.waddr = cnt_one_q[ADDR_W-1:0];
    req_two_o.waddr = cnt_two_q[ADDR_W-1:0];
    req_one_o.wdata = data_t'(in_value_i);
    req_two_o.wdata = data_t'(in_value_i);

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_op_i == OP_LOAD_ONE) begin
            if (cnt_one_q < CNT_W'(LIST_DEPTH)) begin
              req_one_o.we = 1'b1;
              cnt_one_d    = cnt_one_q + 1'b1;
            end
          end else if (in_op_i == OP_LOAD_TWO) begin
            if (cnt_two_q < CNT_W'(LIST_DEPTH)) begin
              req_two_o.we = 1'b1;
              cnt_two_d    = cnt_two_q + 1'b1;
            end
          end else if (in_op_i == OP_MERGE) begin
            // Lengths are latched so the counts clear right away.
            num_one_d = cnt_one_q;
            num_two_d = cnt_two_q;
            cnt_one_d = '0;
            cnt_two_d = '0;
            idx_one_d = '0;
            idx_two_d = '0;
            rem_d     = total;
            if (total != '0) begin
              state_d = ST_MERGE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_MERGE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_value_d = VALUE_W'($signed(pick));
          out_last_d  = (rem_q == REM_W'(1));
          rem_d       = rem_q - 1'b1;
          if (take_one) begin
            idx_one_d = idx_one_q + 1'b1;
          end else begin
            idx_two_d = idx_two_q + 1'b1;
          end
          if (rem_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // The read address follows the next pointer so the head word is ready next cycle.
    req_one_o.raddr = idx_one_d[ADDR_W-1:0];
    req_two_o.raddr = idx_two_d[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_one_q   <= '0;
      cnt_two_q   <= '0;
      num_one_q   <= '0;
      num_two_q   <= '0;
      idx_one_q   <= '0;
      idx_two_q   <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_one_q   <= cnt_one_d;
      cnt_two_q   <= cnt_two_d;
      num_one_q   <= num_one_d;
      num_two_q   <= num_two_d;
      idx_one_q   <= idx_one_d;
      idx_two_q   <= idx_two_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_merge_top.sv =====
// Top level of the sorted list merge block: two list stores and the merge controller.
//
//   Channel   Dir   tdata                  tuser      tlast
//   s_axis    in    value [31:0]           op [1:0]   -
//   m_axis    out   merged_value [31:0]    -          last
//
// A load word (op 0 or 1) writes one store entry unless that store is already
// full, in which case it is dropped; loads can follow each other in every cycle.
// The results of a merge word leave at one word per cycle while m_axis_tready is
// high, paced by the single read port of each store.
// While a merge is streaming, s_axis_tready stays low; stalls on m_axis hold
// the result register and the read pointers.
// Reset clears the counts, pointers and the result valid; store contents are
// undefined until loaded and need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_merge_top
  import slm_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // Input words.
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire  [VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  wire  [OP_W-1:0]     s_axis_tuser,   // [1:0] op
  // Result words.
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [VALUE_W-1:0]  m_axis_tdata,   // [31:0] merged_value
  output logic                m_axis_tlast
);

  store_req_t req_one, req_two;
  data_t      rd_one, rd_two;

  // Store for list one; its head word is read every cycle.
  slm_list_store u_store_one (
    .clk_i   (clk_i),
    .req_i   (req_one),
    .rdata_o (rd_one)
  );

  // Store for list two.
  slm_list_store u_store_two (
    .clk_i   (clk_i),
    .req_i   (req_two),
    .rdata_o (rd_two)
  );

  // The controller compares the two head words and picks list one on a tie.
  slm_merge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .req_one_o   (req_one),
    .req_two_o   (req_two),
    .rd_one_i    (rd_one),
    .rd_two_i    (rd_two),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/slm_checker.sv =====
// Port checker for the sorted list merge block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_merge_top_assert.svh"

module slm_checker
  import slm_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_axis_tvalid,
  input wire                s_axis_tready,
  input wire [VALUE_W-1:0]  s_axis_tdata,
  input wire [OP_W-1:0]     s_axis_tuser,
  input wire                m_axis_tvalid,
  input wire                m_axis_tready,
  input wire [VALUE_W-1:0]  m_axis_tdata,
  input wire                m_axis_tlast
);

  `SLM_ASSERT(a_out_valid_holds, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
              "result word dropped before it was taken")
  `SLM_ASSERT(a_out_word_holds, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tready |=>
                $stable(m_axis_tdata) && $stable(m_axis_tlast),
              "stalled result word changed")
  `SLM_ASSERT(a_no_input_mid_merge, clk_i, rst_ni,
              m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready,
              "input taken while a merge is still streaming")
  `SLM_ASSERT(a_in_word_holds, clk_i, rst_ni,
              s_axis_tvalid && !s_axis_tready |=>
                s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser),
              "waiting input word changed")
  `SLM_ASSERT_IN_RST(a_reset_quiet, clk_i, rst_ni, !m_axis_tvalid, "result valid during reset")

endmodule

bind sorted_list_merge_top slm_checker u_slm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
